FILE: rtl/b58_pkg.sv
// shared types, defaults and the base58 alphabet for the base58 encoder
package b58_pkg;

   localparam int MAX_BYTES_DEFAULT = 32;
   localparam int MAX_CHARS_DEFAULT = 44;

   // ascii '1', the character of digit zero and of each leading zero byte
   localparam logic [6:0] ZERO_CHAR = 7'd49;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_CONV_INIT,
      ST_CONV_CHECK,
      ST_PASS_START,
      ST_PASS_RUN,
      ST_PASS_END,
      ST_EMIT_INIT,
      ST_EMIT_READ,
      ST_EMIT_LOAD,
      ST_EMIT_WAIT
   } state_type;

   typedef struct packed {
      logic store;
      logic conv_init;
      logic pass_start;
      logic pass_run;
      logic pass_end;
      logic emit_init;
      logic emit_read;
      logic emit_load;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic more_passes;
      logic pass_last;
      logic rsp_taken;
      logic char_last;
   } status_type;

   // bitcoin alphabet: digits 1 to 9, then letters without I, O and l
   function automatic logic [6:0] b58_char(input logic [5:0] digit);
      logic [6:0] code;
      priority if (digit < 6'd9) begin
         code = 7'd49 + {1'b0, digit};
      end else if (digit < 6'd17) begin
         code = 7'd65 + {1'b0, digit - 6'd9};
      end else if (digit < 6'd22) begin
         code = 7'd74 + {1'b0, digit - 6'd17};
      end else if (digit < 6'd33) begin
         code = 7'd80 + {1'b0, digit - 6'd22};
      end else if (digit < 6'd44) begin
         code = 7'd97 + {1'b0, digit - 6'd33};
      end else begin
         code = 7'd109 + {1'b0, digit - 6'd44};
      end
      return code;
   endfunction

endpackage

FILE: rtl/base58_encoder.sv
// collection: one byte word per cycle; the word marked last starts the conversion
// conversion: one divide-by-58 pass per base58 digit (about 1.37 per byte), each pass
//   running over the unsettled stored bytes in a start, a run and an end state
// output: each character word is read, loaded and then held until rsp_ready takes it; the next string
//   is taken once the last character word has gone
// reset: synchronous; clears the state machine, byte and zero-prefix counters, overflow flag and rsp_valid
module base58_encoder #(
   parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEFAULT,
   parameter int MAX_CHARS = b58_pkg::MAX_CHARS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [6:0] rsp_char_code,
   output logic       rsp_last_char,
   output logic       rsp_overflow
);
   import b58_pkg::*;

   cmd_type    cmd;
   status_type status;

   b58_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_byte (req_last_byte),
      .status        (status),
      .req_ready     (req_ready),
      .cmd           (cmd)
   );

   b58_dpath #(
      .MAX_BYTES (MAX_BYTES),
      .MAX_CHARS (MAX_CHARS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data_byte (req_data_byte),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

FILE: rtl/b58_ctrl.sv
// sequencer for collection, divide passes and character output
module b58_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last_byte,
   input  b58_pkg::status_type  status,
   output logic                 req_ready,
   output b58_pkg::cmd_type     cmd
);
   import b58_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store = 1'b1;
               if (req_last_byte) begin
                  state_in = ST_CONV_INIT;
               end
            end
         end
         ST_CONV_INIT: begin
            cmd.conv_init = 1'b1;
            state_in      = ST_CONV_CHECK;
         end
         ST_CONV_CHECK: begin
            if (status.more_passes) begin
               state_in = ST_PASS_START;
            end else begin
               state_in = ST_EMIT_INIT;
            end
         end
         ST_PASS_START: begin
            cmd.pass_start = 1'b1;
            state_in       = ST_PASS_RUN;
         end
         ST_PASS_RUN: begin
            cmd.pass_run = 1'b1;
            if (status.pass_last) begin
               state_in = ST_PASS_END;
            end
         end
         ST_PASS_END: begin
            cmd.pass_end = 1'b1;
            state_in     = ST_CONV_CHECK;
         end
         ST_EMIT_INIT: begin
            cmd.emit_init = 1'b1;
            state_in      = ST_EMIT_READ;
         end
         ST_EMIT_READ: begin
            cmd.emit_read = 1'b1;
            state_in      = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            cmd.emit_load = 1'b1;
            state_in      = ST_EMIT_WAIT;
         end
         ST_EMIT_WAIT: begin
            if (status.rsp_taken) begin
               if (status.char_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_COLLECT;
               end else begin
                  state_in = ST_EMIT_READ;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

endmodule

FILE: rtl/b58_dpath.sv
// byte store, divide-by-58 unit, digit store and output register
module b58_dpath #(
   parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEFAULT,
   parameter int MAX_CHARS = b58_pkg::MAX_CHARS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  b58_pkg::cmd_type     cmd,
   output b58_pkg::status_type  status,
   input  logic [7:0]           req_data_byte,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [6:0]           rsp_char_code,
   output logic                 rsp_last_char,
   output logic                 rsp_overflow
);
   import b58_pkg::*;

   localparam int WORK_DIGITS = 2 * MAX_BYTES + 2;
   localparam int CW  = $clog2(MAX_BYTES + 1);
   localparam int BA  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int RA  = $clog2(WORK_DIGITS);
   localparam int RW  = $clog2(WORK_DIGITS + 1);
   localparam int TW  = $clog2(MAX_CHARS + 1);
   localparam int M1  = (CW > RW) ? CW : RW;
   localparam int SW  = ((M1 > TW) ? M1 : TW) + 1;

   // x / 58 == (x * 565) >> 15 exactly for every x below 58 * 256
   localparam logic [9:0] RECIP = 10'd565;

   // collection state
   logic [CW-1:0] byte_count_ff, byte_count_in;
   logic [CW-1:0] zpc_ff, zpc_in;
   logic          ovf_ff, ovf_in;
   logic          store_ok;

   // byte store
   logic [7:0]    byte_store_ff [MAX_BYTES];
   logic [7:0]    byte_rd_ff;
   logic          bs_we, bs_re;
   logic [BA-1:0] bs_waddr, bs_raddr;
   logic [7:0]    bs_wdata;

   // divide pass
   logic [CW-1:0] s_ff, k_ff, wr_ff;
   logic [5:0]    rem_ff;
   logic          first_zero_ff;
   logic [RW-1:0] nrev_ff, ndig_ff;
   logic [13:0]   dividend;
   logic [23:0]   product;
   logic [7:0]    quot;
   logic [13:0]   quot_x58;
   logic [13:0]   rem_full;
   logic [5:0]    rem_next;

   // digit store, least significant digit first
   logic [5:0]    rev_store_ff [WORK_DIGITS];
   logic [5:0]    rev_rd_ff;
   logic [RA-1:0] rev_raddr;
   logic [SW-1:0] rev_pos;

   // output
   logic [TW-1:0] eidx_ff, total_ff;
   logic [SW-1:0] char_sum;
   logic          in_ones;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    char_ff;
   logic          last_ff;

   assign store_ok = byte_count_ff < CW'(MAX_BYTES);

   always_comb begin
      byte_count_in = byte_count_ff;
      zpc_in        = zpc_ff;
      ovf_in        = ovf_ff;
      if (cmd.store) begin
         if (store_ok) begin
            if (req_data_byte == 8'd0 && zpc_ff == byte_count_ff) begin
               zpc_in = zpc_ff + CW'(1);
            end
            byte_count_in = byte_count_ff + CW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         byte_count_in = '0;
         zpc_in        = '0;
         ovf_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         zpc_ff        <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         zpc_ff        <= zpc_in;
         ovf_ff        <= ovf_in;
      end
   end

   // long division step: bring down one byte under the running remainder
   assign dividend = {rem_ff, byte_rd_ff};
   assign product  = dividend * RECIP;
   assign quot     = product[22:15];
   assign quot_x58 = {quot, 6'd0} - {3'd0, quot, 3'd0} + {5'd0, quot, 1'b0};
   assign rem_full = dividend - quot_x58;
   assign rem_next = rem_full[5:0];

   assign status.pass_last   = (wr_ff == byte_count_ff - CW'(1));
   assign status.more_passes = (s_ff < byte_count_ff) && (nrev_ff < RW'(WORK_DIGITS));

   always_comb begin
      bs_we    = 1'b0;
      bs_waddr = byte_count_ff[BA-1:0];
      bs_wdata = req_data_byte;
      if (cmd.store && store_ok) begin
         bs_we = 1'b1;
      end else if (cmd.pass_run) begin
         bs_we    = 1'b1;
         bs_waddr = wr_ff[BA-1:0];
         bs_wdata = quot;
      end
      bs_re    = cmd.pass_start || (cmd.pass_run && !status.pass_last);
      bs_raddr = cmd.pass_start ? s_ff[BA-1:0] : k_ff[BA-1:0];
   end

   always_ff @(posedge clock) begin
      if (bs_we) begin
         byte_store_ff[bs_waddr] <= bs_wdata;
      end
      if (bs_re) begin
         byte_rd_ff <= byte_store_ff[bs_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.conv_init) begin
         s_ff    <= zpc_ff;
         nrev_ff <= '0;
         ndig_ff <= '0;
      end
      if (cmd.pass_start) begin
         k_ff   <= s_ff + CW'(1);
         wr_ff  <= s_ff;
         rem_ff <= 6'd0;
      end
      if (cmd.pass_run) begin
         rem_ff <= rem_next;
         if (wr_ff == s_ff) begin
            first_zero_ff <= (quot == 8'd0);
         end
         if (!status.pass_last) begin
            k_ff  <= k_ff + CW'(1);
            wr_ff <= k_ff;
         end
      end
      if (cmd.pass_end) begin
         nrev_ff <= nrev_ff + RW'(1);
         // zero digits at the top are trimmed, so track the highest non-zero one
         if (rem_ff != 6'd0) begin
            ndig_ff <= nrev_ff + RW'(1);
         end
         if (first_zero_ff) begin
            s_ff <= s_ff + CW'(1);
         end
      end
   end

   // output sequencing: leading ones first, then digits from the top down
   assign char_sum = SW'(zpc_ff) + SW'(ndig_ff);
   assign in_ones  = SW'(eidx_ff) < SW'(zpc_ff);
   assign rev_pos  = char_sum - SW'(1) - SW'(eidx_ff);
   assign rev_raddr = in_ones ? '0 : rev_pos[RA-1:0];

   always_ff @(posedge clock) begin
      if (cmd.pass_end) begin
         rev_store_ff[nrev_ff[RA-1:0]] <= rem_ff;
      end
      if (cmd.emit_read) begin
         rev_rd_ff <= rev_store_ff[rev_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_init) begin
         eidx_ff  <= '0;
         total_ff <= (char_sum > SW'(MAX_CHARS)) ? TW'(MAX_CHARS) : char_sum[TW-1:0];
      end
      if (cmd.emit_load) begin
         char_ff <= in_ones ? ZERO_CHAR : b58_char(rev_rd_ff);
         last_ff <= (eidx_ff + TW'(1)) == total_ff;
         eidx_ff <= eidx_ff + TW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.rsp_taken = rsp_valid_ff && rsp_ready;
   assign status.char_last = last_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;
   assign rsp_overflow  = ovf_ff;

endmodule

FILE: verif/b58_scoreboard_pkg.sv
`timescale 1ns / 1ps
// scoreboard class that predicts and checks the base58 character words
package b58_check_pkg;

   localparam int STORE_DEPTH = b58_pkg::MAX_BYTES_DEFAULT;
   localparam int CHAR_LIMIT = b58_pkg::MAX_CHARS_DEFAULT;
   localparam int WORK_DIGITS = 2 * STORE_DEPTH + 2;
   localparam int REPORT_LIMIT = 10;
   localparam string B58_LETTERS =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   typedef struct packed {
      logic [6:0] code;
      logic       last;
      logic       overflow;
   } char_word_type;

   class char_scoreboard;
      logic [7:0] held_bytes[STORE_DEPTH];
      int         held_count;
      int         zero_lead;
      bit         dropped;
      char_word_type expected_chars[$];
      int         errors;

      function new();
         held_count = 0;
         zero_lead = 0;
         dropped = 0;
         errors = 0;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      function void report(string what);
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("tb: %s", what);
         end
      endfunction

      // big-endian string to base58 by repeated division, leading zero bytes as '1'
      function void encode_string();
         logic [7:0] work[STORE_DEPTH];
         logic [5:0] rev_digits[WORK_DIGITS];
         logic [5:0] digits[$];
         char_word_type word;
         int n_rev;
         int lead;
         int rem;
         int k;
         n_rev = 0;
         lead = zero_lead;
         for (k = 0; k < held_count; k++) begin
            work[k] = held_bytes[k];
         end
         while (lead < held_count && n_rev < WORK_DIGITS) begin
            rem = 0;
            for (k = lead; k < held_count; k++) begin
               rem = rem * 256 + int'(work[k]);
               work[k] = 8'(rem / 58);
               rem = rem % 58;
            end
            rev_digits[n_rev] = 6'(rem);
            n_rev++;
            if (work[lead] == 8'd0) begin
               lead++;
            end
         end
         // zero digits at the top are not part of the value
         while (n_rev > 0 && rev_digits[n_rev - 1] == 6'd0) begin
            n_rev--;
         end
         for (k = 0; k < zero_lead && digits.size() < CHAR_LIMIT; k++) begin
            digits.push_back(6'd0);
         end
         while (n_rev > 0 && digits.size() < CHAR_LIMIT) begin
            n_rev--;
            digits.push_back(rev_digits[n_rev]);
         end
         for (k = 0; k < digits.size(); k++) begin
            word.code = 7'(B58_LETTERS[digits[k]]);
            word.last = (k == digits.size() - 1);
            word.overflow = dropped;
            expected_chars.push_back(word);
         end
      endfunction

      function void note_byte(logic [7:0] data, logic last);
         if (held_count < STORE_DEPTH) begin
            if (data == 8'd0 && zero_lead == held_count) begin
               zero_lead++;
            end
            held_bytes[held_count] = data;
            held_count++;
         end else begin
            dropped = 1;
         end
         if (last) begin
            encode_string();
            held_count = 0;
            zero_lead = 0;
            dropped = 0;
         end
      endfunction

      function void check_char(logic [6:0] code, logic last, logic overflow);
         char_word_type want;
         if (expected_chars.size() == 0) begin
            report($sformatf("unexpected word: char 0x%02h last %0b overflow %0b",
                             code, last, overflow));
         end else begin
            want = expected_chars.pop_front();
            if (want.code !== code || want.last !== last || want.overflow !== overflow) begin
               report($sformatf({"mismatch: expected char 0x%02h last %0b overflow %0b,",
                                 " got char 0x%02h last %0b overflow %0b"},
                                want.code, want.last, want.overflow, code, last, overflow));
            end
         end
      endfunction
   endclass

endpackage

FILE: verif/tb.sv
`timescale 1ns / 1ps
// top-level bench for the base58 encoder: byte strings in, checked character words out
module tb;
   import b58_check_pkg::*;

   localparam int TARGET_ITEMS = 250;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int TAIL_CYCLES = 100;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'd0;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [6:0] rsp_char_code;
   logic       rsp_last_char;
   logic       rsp_overflow;

   char_scoreboard sb;
   logic [7:0] str_bytes[$];
   int         sent_items = 0;
   int         idle_cycles = 0;
   int         stall_left = 0;
   bit         req_calm = 0;
   bit         rsp_calm = 0;

   base58_encoder DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last_char(rsp_last_char),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // call at a rising edge; returns at the edge where the word is taken
   task automatic send_word(input logic [7:0] data, input logic last, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sb.note_byte(data, last);
      sent_items++;
   endtask

   task automatic send_held_string();
      foreach (str_bytes[i]) begin
         send_word(str_bytes[i], i == str_bytes.size() - 1, pick_gap(req_calm));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_string(input bit force_long);
      int len;
      int zeros;
      int roll;
      roll = force_long ? 99 : $urandom_range(0, 99);
      if (roll < 68) begin
         len = $urandom_range(1, 6);
      end else if (roll < 86) begin
         len = $urandom_range(7, 31);
      end else if (roll < 92) begin
         len = b58_check_pkg::STORE_DEPTH;
      end else begin
         len = $urandom_range(b58_check_pkg::STORE_DEPTH + 1, b58_check_pkg::STORE_DEPTH + 8);
      end
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
         zeros = len;
      end else if (roll < 40) begin
         zeros = $urandom_range(1, 3);
      end else begin
         zeros = 0;
      end
      str_bytes.delete();
      for (int i = 0; i < len; i++) begin
         str_bytes.push_back(i < zeros ? 8'h00 : 8'($urandom_range(0, 255)));
      end
      send_held_string();
   endtask

   // receiver back-pressure, with calm stretches
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) begin
         rsp_calm = ~rsp_calm;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = pick_gap(rsp_calm);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_char(rsp_char_code, rsp_last_char, rsp_overflow);
      end
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // single bytes at the edges of the range and around one digit
      str_bytes = '{8'h00};               send_held_string();
      str_bytes = '{8'hff};               send_held_string();
      str_bytes = '{8'h01};               send_held_string();
      str_bytes = '{8'h39};               send_held_string();
      str_bytes = '{8'h3a};               send_held_string();
      // multi-byte strings: all zeros, leading and trailing zero bytes, and all ones
      str_bytes = '{8'h00, 8'h00};        send_held_string();
      str_bytes = '{8'h00, 8'h01};        send_held_string();
      str_bytes = '{8'h00, 8'h00, 8'hff}; send_held_string();
      str_bytes = '{8'h80, 8'h00};        send_held_string();
      str_bytes = '{8'hff, 8'hff, 8'hff, 8'hff}; send_held_string();
      str_bytes = '{8'h00, 8'hff, 8'h00}; send_held_string();
      str_bytes = '{8'h3a, 8'h00, 8'h00}; send_held_string();

      // hold off until the encoder has emptied
      wait_drained();

      // first random string always overruns the store
      send_random_string(1'b1);
      while (sent_items < TARGET_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            req_calm = ~req_calm;
         end
         if ($urandom_range(0, 9) == 0) begin
            wait_drained();
         end
         send_random_string(1'b0);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
